[src/perspective_point_project_core_assert.svh]
// Assertion macros for the perspective point projection core.
`ifndef PERSPECTIVE_POINT_PROJECT_CORE_ASSERT_SVH
`define PERSPECTIVE_POINT_PROJECT_CORE_ASSERT_SVH

// Same-cycle implication checked at every clock edge outside reset.
`define PPPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked at every clock edge outside reset.
`define PPPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/pppc_pkg.sv]
// ----------------------------------------------------------------------------
// pppc_pkg
// Shared widths, constants and types of the perspective point projection core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pppc_pkg;

    localparam int COORD_W = 16;
    localparam int ROW_W   = 64;
    localparam int PROD_W  = 32;
    localparam int ACC_W   = 34;
    localparam int MAG_W   = 34;
    localparam int SX_W    = 11;
    localparam int SY_W    = 10;
    localparam int IDX_W   = 2;
    localparam int FRAC_SH = 11;

    localparam int DEF_VIEW_WIDTH  = 1024;
    localparam int DEF_VIEW_HEIGHT = 768;

    localparam logic [SX_W-1:0] SX_MAX = '1;
    localparam logic [SY_W-1:0] SY_MAX = '1;

    localparam logic [IDX_W-1:0] REG_ROW0 = 2'd0;
    localparam logic [IDX_W-1:0] REG_ROW1 = 2'd1;
    localparam logic [IDX_W-1:0] REG_ROW2 = 2'd2;
    localparam logic [IDX_W-1:0] REG_ROW3 = 2'd3;

    localparam logic [ROW_W-1:0] ROW0_RST = 64'h0000_0000_0000_0800;
    localparam logic [ROW_W-1:0] ROW1_RST = 64'h0000_0000_0800_0000;
    localparam logic [ROW_W-1:0] ROW3_RST = 64'h0800_0000_0000_0000;

    // Clipped point handed to the divider: numerators and common denominator.
    typedef struct packed {
        logic             ok;
        logic [MAG_W-1:0] num_x;
        logic [MAG_W-1:0] num_y;
        logic [MAG_W-1:0] den;
    } t_clip;

endpackage
`default_nettype wire

[src/perspective_point_project_core.sv]
// ----------------------------------------------------------------------------
// perspective_point_project_core
// Projects world-space points through a loadable 4x4 transform to pixels.
// ----------------------------------------------------------------------------
//  Channel  Handshake                  Payload
//  input    i_valid / o_ready          i_world_x, i_world_y, i_world_z
//  output   o_valid / i_ready          o_screen_x, o_screen_y, o_onscreen
//  config   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item enters per cycle while the output is not stalled. The pipeline is
// two transform stages, one clip stage, one scale stage, and one restoring
// division stage per quotient bit, clog2(max(view size) + 1) bits in all.
// Reset is synchronous and loads the identity matrix. Each stage holds its
// item while the next one is full, so a stall loses and repeats nothing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "perspective_point_project_core_assert.svh"
module perspective_point_project_core
    import pppc_pkg::*;
#(
    parameter int VIEW_WIDTH  = DEF_VIEW_WIDTH,
    parameter int VIEW_HEIGHT = DEF_VIEW_HEIGHT
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_ready,
    input  wire  signed [COORD_W-1:0] i_world_x,
    input  wire  signed [COORD_W-1:0] i_world_y,
    input  wire  signed [COORD_W-1:0] i_world_z,
    output logic                      o_valid,
    input  wire                       i_ready,
    output logic [SX_W-1:0]           o_screen_x,
    output logic [SY_W-1:0]           o_screen_y,
    output logic                      o_onscreen,
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire  [IDX_W-1:0]          i_cfg_index,
    input  wire  [ROW_W-1:0]          i_cfg_data
);

    logic [ROW_W-1:0]        r_row0, r_row1, r_row3;
    logic                    w_xf_valid, w_xf_ready;
    logic signed [ACC_W-1:0] w_cx, w_cy, w_cw;
    logic                    w_cl_valid, w_cl_ready;
    t_clip                   w_clip;

    assign o_cfg_ready = 1'b1;

    // The Z row feeds nothing downstream, so it has no storage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0 <= ROW0_RST;
            r_row1 <= ROW1_RST;
            r_row3 <= ROW3_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ROW0: r_row0 <= i_cfg_data;
                REG_ROW1: r_row1 <= i_cfg_data;
                REG_ROW2: ;
                REG_ROW3: r_row3 <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    pppc_xform u_xform (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_row0    (r_row0),
        .i_row1    (r_row1),
        .i_row3    (r_row3),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_world_x (i_world_x),
        .i_world_y (i_world_y),
        .i_world_z (i_world_z),
        .o_valid   (w_xf_valid),
        .i_ready   (w_xf_ready),
        .o_cx      (w_cx),
        .o_cy      (w_cy),
        .o_cw      (w_cw)
    );

    pppc_clip u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_xf_valid),
        .o_ready (w_xf_ready),
        .i_cx    (w_cx),
        .i_cy    (w_cy),
        .i_cw    (w_cw),
        .o_valid (w_cl_valid),
        .i_ready (w_cl_ready),
        .o_clip  (w_clip)
    );

    pppc_div #(
        .VIEW_WIDTH  (VIEW_WIDTH),
        .VIEW_HEIGHT (VIEW_HEIGHT)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_cl_valid),
        .o_ready    (w_cl_ready),
        .i_clip     (w_clip),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_screen_x (o_screen_x),
        .o_screen_y (o_screen_y),
        .o_onscreen (o_onscreen)
    );

    `PPPC_ASSERT_IMPLY(a_offscreen_zero, i_clk, i_rst_n, o_valid && !o_onscreen, o_screen_x == '0 && o_screen_y == '0)
    `PPPC_ASSERT_IMPLY(a_clip_needs_w, i_clk, i_rst_n, w_cl_valid && w_clip.ok, w_clip.den != '0)
    `PPPC_ASSERT_NEXT(a_stall_holds_result, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_screen_x) && $stable(o_onscreen))

endmodule
`default_nettype wire

[src/pppc_xform.sv]
// ----------------------------------------------------------------------------
// pppc_xform
// Two-stage matrix transform: lane products, then row sums for X, Y and W.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pppc_xform
    import pppc_pkg::*;
(
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire  [ROW_W-1:0]          i_row0,
    input  wire  [ROW_W-1:0]          i_row1,
    input  wire  [ROW_W-1:0]          i_row3,
    input  wire                       i_valid,
    output logic                      o_ready,
    input  wire  signed [COORD_W-1:0] i_world_x,
    input  wire  signed [COORD_W-1:0] i_world_y,
    input  wire  signed [COORD_W-1:0] i_world_z,
    output logic                      o_valid,
    input  wire                       i_ready,
    output logic signed [ACC_W-1:0]   o_cx,
    output logic signed [ACC_W-1:0]   o_cy,
    output logic signed [ACC_W-1:0]   o_cw
);

    logic                      r_v1, r_v2;
    logic signed [PROD_W-1:0]  r_prod [0:2][0:2];
    logic signed [COORD_W-1:0] r_c3   [0:2];
    logic signed [ACC_W-1:0]   r_cx, r_cy, r_cw;
    logic signed [ACC_W-1:0]   n_sum  [0:2];
    logic                      w_en1, w_en2;
    logic [ROW_W-1:0]          w_rows [0:2];
    logic signed [COORD_W-1:0] w_pt   [0:2];

    assign w_en2   = !r_v2 || i_ready;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    assign w_rows[0] = i_row0;
    assign w_rows[1] = i_row1;
    assign w_rows[2] = i_row3;
    assign w_pt[0]   = i_world_x;
    assign w_pt[1]   = i_world_y;
    assign w_pt[2]   = i_world_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            for (int r = 0; r < 3; r++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[r][j] <= $signed(w_rows[r][16*j +: COORD_W]) * w_pt[j];
                end
                // The w lane multiplies 1.0, which is a plain shift of the coefficient.
                r_c3[r] <= $signed(w_rows[r][48 +: COORD_W]);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_sum[r] = ACC_W'(r_prod[r][0]) + ACC_W'(r_prod[r][1]) + ACC_W'(r_prod[r][2])
                     + (ACC_W'(r_c3[r]) <<< FRAC_SH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_cx <= n_sum[0];
            r_cy <= n_sum[1];
            r_cw <= n_sum[2];
        end
    end

    assign o_valid = r_v2;
    assign o_cx    = r_cx;
    assign o_cy    = r_cy;
    assign o_cw    = r_cw;

endmodule
`default_nettype wire

[src/pppc_clip.sv]
// ----------------------------------------------------------------------------
// pppc_clip
// Sign fold on W, view range test and division operands for both axes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pppc_clip
    import pppc_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire  signed [ACC_W-1:0] i_cx,
    input  wire  signed [ACC_W-1:0] i_cy,
    input  wire  signed [ACC_W-1:0] i_cw,
    output logic                    o_valid,
    input  wire                     i_ready,
    output t_clip                   o_clip
);

    logic                  r_v;
    t_clip                 r_clip;
    logic                  w_en;
    logic signed [ACC_W:0] n_x, n_y, n_w;
    t_clip                 n_clip;

    assign w_en    = !r_v || i_ready;
    assign o_ready = w_en;

    always_comb begin
        // Negating all three leaves x/w and y/w unchanged.
        if (i_cw < 0) begin
            n_x = -(ACC_W+1)'(i_cx);
            n_y = -(ACC_W+1)'(i_cy);
            n_w = -(ACC_W+1)'(i_cw);
        end else begin
            n_x = (ACC_W+1)'(i_cx);
            n_y = (ACC_W+1)'(i_cy);
            n_w = (ACC_W+1)'(i_cw);
        end
        n_clip.ok    = (n_w != 0) && (n_x >= -n_w) && (n_x <= n_w)
                    && (n_y >= -n_w) && (n_y <= n_w);
        n_clip.num_x = MAG_W'(n_x + n_w);
        n_clip.num_y = MAG_W'(n_w - n_y);
        n_clip.den   = MAG_W'(n_w <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_clip <= n_clip;
    end

    assign o_valid = r_v;
    assign o_clip  = r_clip;

endmodule
`default_nettype wire

[src/pppc_div.sv]
// ----------------------------------------------------------------------------
// pppc_div
// Pixel mapping: scale by the view size, then a restoring division that
// resolves one quotient bit per stage for both axes side by side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pppc_div
    import pppc_pkg::*;
#(
    parameter int VIEW_WIDTH  = DEF_VIEW_WIDTH,
    parameter int VIEW_HEIGHT = DEF_VIEW_HEIGHT
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  t_clip             i_clip,
    output logic              o_valid,
    input  wire               i_ready,
    output logic [SX_W-1:0]   o_screen_x,
    output logic [SY_W-1:0]   o_screen_y,
    output logic              o_onscreen
);

    localparam int VMAX = (VIEW_WIDTH > VIEW_HEIGHT) ? VIEW_WIDTH : VIEW_HEIGHT;
    localparam int QW   = $clog2(VMAX + 1);
    localparam int DW   = MAG_W + QW;
    localparam int NS   = QW + 1;

    logic              r_v   [0:NS-1];
    logic              r_ok  [0:NS-1];
    logic [DW-1:0]     r_rx  [0:NS-1];
    logic [DW-1:0]     r_ry  [0:NS-1];
    logic [MAG_W-1:0]  r_den [0:NS-1];
    logic [QW-1:0]     r_qx  [0:NS-1];
    logic [QW-1:0]     r_qy  [0:NS-1];
    logic              w_en  [0:NS];

    assign w_en[NS] = i_ready;
    assign o_ready  = w_en[0];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        assign w_en[k] = !r_v[k] || w_en[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_v[k] <= (k == 0) ? i_valid : r_v[(k == 0) ? 0 : k-1];
            end
        end

        if (k == 0) begin : g_scale
            always_ff @(posedge i_clk) begin
                if (w_en[0]) begin
                    r_ok[0]  <= i_clip.ok;
                    r_rx[0]  <= DW'(i_clip.num_x) * DW'(VIEW_WIDTH);
                    r_ry[0]  <= DW'(i_clip.num_y) * DW'(VIEW_HEIGHT);
                    r_den[0] <= i_clip.den;
                    r_qx[0]  <= '0;
                    r_qy[0]  <= '0;
                end
            end
        end else begin : g_bit
            localparam int B = QW - k;
            logic [DW-1:0] w_dsh;
            assign w_dsh = DW'(r_den[k-1]) << B;

            always_ff @(posedge i_clk) begin
                if (w_en[k]) begin
                    r_ok[k]  <= r_ok[k-1];
                    r_den[k] <= r_den[k-1];
                    if (r_rx[k-1] >= w_dsh) begin
                        r_rx[k] <= r_rx[k-1] - w_dsh;
                        r_qx[k] <= r_qx[k-1] | (QW'(1) << B);
                    end else begin
                        r_rx[k] <= r_rx[k-1];
                        r_qx[k] <= r_qx[k-1];
                    end
                    if (r_ry[k-1] >= w_dsh) begin
                        r_ry[k] <= r_ry[k-1] - w_dsh;
                        r_qy[k] <= r_qy[k-1] | (QW'(1) << B);
                    end else begin
                        r_ry[k] <= r_ry[k-1];
                        r_qy[k] <= r_qy[k-1];
                    end
                end
            end
        end
    end

    // The final remainders are not needed; the quotient is the truncated pixel.
    always_comb begin
        o_valid    = r_v[NS-1];
        o_onscreen = r_ok[NS-1];
        o_screen_x = '0;
        o_screen_y = '0;
        if (r_ok[NS-1]) begin
            o_screen_x = (32'(r_qx[NS-1]) > 32'(SX_MAX)) ? SX_MAX : SX_W'(r_qx[NS-1]);
            o_screen_y = (32'(r_qy[NS-1]) > 32'(SY_MAX)) ? SY_MAX : SY_W'(r_qy[NS-1]);
        end
    end

endmodule
`default_nettype wire
